// ----- hw/rtl/pia_pkg.sv -----
// Shared types and codes for the peripheral interface adapter.
// No dependencies; compile this file first.
package pia_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] opcode_type;
   typedef logic [1:0] reg_sel_type;
   typedef logic [3:0] upd_mask_type;

   // Request operations.
   localparam opcode_type OP_READ    = 3'd0;
   localparam opcode_type OP_WRITE   = 3'd1;
   localparam opcode_type OP_SET_CA1 = 3'd2;
   localparam opcode_type OP_SET_CA2 = 3'd3;
   localparam opcode_type OP_SET_CB1 = 3'd4;
   localparam opcode_type OP_SET_CB2 = 3'd5;

   // Register addresses.
   localparam reg_sel_type RS_PORT_A = 2'd0;
   localparam reg_sel_type RS_CTRL_A = 2'd1;
   localparam reg_sel_type RS_PORT_B = 2'd2;
   localparam reg_sel_type RS_CTRL_B = 2'd3;

   // Control register bit positions.
   localparam int CR_IRQ1     = 7;
   localparam int CR_IRQ2     = 6;
   localparam int CR_L2_OUT   = 5;
   localparam int CR_L2_MAN   = 4;
   localparam int CR_L2_LVL   = 3;
   localparam int CR_DATA_SEL = 2;
   localparam int CR_L1_EDGE  = 1;

   // Control bits 5..3 that select the pulse strobe mode on line 2.
   localparam logic [2:0] L2_STROBE_MODE = 3'b101;

   // Line level positions.
   localparam int LN_CA1 = 0;
   localparam int LN_CA2 = 1;
   localparam int LN_CB1 = 2;
   localparam int LN_CB2 = 3;

   // Sticky event flag positions.
   localparam int EV_CA2_CHG = 0;
   localparam int EV_CB2_CHG = 1;
   localparam int EV_CA2_STB = 2;
   localparam int EV_CB2_STB = 3;
   localparam int EV_UPD_CA2 = 4;
   localparam int EV_UPD_CB2 = 5;
   localparam int EV_UPD_PA  = 6;
   localparam int EV_UPD_PB  = 7;

endpackage

// ----- hw/rtl/pia_req_if.sv -----
// Request channel of the peripheral interface adapter: valid/ready plus payload.
// Depends on pia_pkg.
interface pia_req_if
   import pia_pkg::*;
();
   logic        valid;
   logic        ready;
   opcode_type  opcode;
   reg_sel_type reg_select;
   byte_type    data_in;
   byte_type    port_a_pins;
   byte_type    port_b_pins;

   modport source (output valid, opcode, reg_select, data_in, port_a_pins, port_b_pins,
                   input ready);
   modport sink   (input valid, opcode, reg_select, data_in, port_a_pins, port_b_pins,
                   output ready);
endinterface

// ----- hw/rtl/pia_rsp_if.sv -----
// Response channel of the peripheral interface adapter: valid/ready plus payload.
// Depends on pia_pkg.
interface pia_rsp_if
   import pia_pkg::*;
();
   logic         valid;
   logic         ready;
   byte_type     read_data;
   byte_type     port_a_out;
   byte_type     port_b_out;
   byte_type     port_a_toggled;
   byte_type     port_b_toggled;
   logic         ca2_level;
   logic         cb2_level;
   logic         ca2_flipped;
   logic         cb2_flipped;
   logic         ca2_strobe;
   logic         cb2_strobe;
   upd_mask_type updated_mask;

   modport source (output valid, read_data, port_a_out, port_b_out, port_a_toggled,
                   port_b_toggled, ca2_level, cb2_level, ca2_flipped, cb2_flipped,
                   ca2_strobe, cb2_strobe, updated_mask,
                   input ready);
   modport sink   (input valid, read_data, port_a_out, port_b_out, port_a_toggled,
                   port_b_toggled, ca2_level, cb2_level, ca2_flipped, cb2_flipped,
                   ca2_strobe, cb2_strobe, updated_mask,
                   output ready);
endinterface

// ----- hw/rtl/peripheral_interface_adapter.sv -----
// Two-port parallel interface adapter (depends on pia_pkg, pia_req_if, pia_rsp_if).
// Each request is a bus read or write of one of four registers, or a level change on
// CA1, CA2, CB1 or CB2; each request produces exactly one response, in the cycle after it
// is accepted. The block takes one request every clock cycle: the register state is
// updated in the accepting cycle and the response sits in a single output register,
// so a new request is taken whenever that register is empty or is being drained.
// The response carries the read byte, both output registers and the sticky flags.
module peripheral_interface_adapter
   import pia_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   pia_req_if.sink  req_chan,
   pia_rsp_if.source rsp_chan
);

   byte_type   ctrl_a_ff, ctrl_a_in, ctrl_b_ff, ctrl_b_in;
   byte_type   dir_a_ff, dir_a_in, dir_b_ff, dir_b_in;
   byte_type   out_a_ff, out_a_in, out_b_ff, out_b_in;
   byte_type   tog_a_ff, tog_a_in, tog_b_ff, tog_b_in;
   byte_type   events_ff, events_in;
   logic [3:0] lines_ff, lines_in;
   logic [1:0] pins2_ff, pins2_in;
   byte_type   read_byte;
   logic       level;
   logic       req_fire;
   logic       rsp_valid_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign level          = |req_chan.data_in;

   always_comb begin
      ctrl_a_in = ctrl_a_ff;
      ctrl_b_in = ctrl_b_ff;
      dir_a_in  = dir_a_ff;
      dir_b_in  = dir_b_ff;
      out_a_in  = out_a_ff;
      out_b_in  = out_b_ff;
      tog_a_in  = tog_a_ff;
      tog_b_in  = tog_b_ff;
      events_in = events_ff;
      lines_in  = lines_ff;
      pins2_in  = pins2_ff;
      read_byte = '0;
      case (req_chan.opcode)
         OP_READ: begin
            events_in[EV_CA2_STB] = 1'b0;
            case (req_chan.reg_select)
               RS_PORT_A: begin
                  if (ctrl_a_ff[CR_DATA_SEL]) begin
                     // Port A pins are not masked by the direction register.
                     read_byte = (out_a_ff & dir_a_ff) | req_chan.port_a_pins;
                     ctrl_a_in[CR_IRQ1] = 1'b0;
                     ctrl_a_in[CR_IRQ2] = 1'b0;
                     if (ctrl_a_ff[5:3] == L2_STROBE_MODE) begin
                        events_in[EV_CA2_STB] = 1'b1;
                     end
                  end else begin
                     read_byte = dir_a_ff;
                  end
               end
               RS_CTRL_A: read_byte = ctrl_a_ff;
               RS_PORT_B: begin
                  if (ctrl_b_ff[CR_DATA_SEL]) begin
                     read_byte = (out_b_ff & dir_b_ff) | (req_chan.port_b_pins & ~dir_b_ff);
                     ctrl_b_in[CR_IRQ1] = 1'b0;
                     ctrl_b_in[CR_IRQ2] = 1'b0;
                  end else begin
                     read_byte = dir_b_ff;
                  end
               end
               default: read_byte = ctrl_b_ff;
            endcase
         end
         OP_WRITE: begin
            tog_a_in  = '0;
            tog_b_in  = '0;
            events_in = '0;
            events_in[EV_CA2_STB] = events_ff[EV_CA2_STB];
            case (req_chan.reg_select)
               RS_PORT_A: begin
                  if (ctrl_a_ff[CR_DATA_SEL]) begin
                     events_in[EV_UPD_PA] = 1'b1;
                     tog_a_in = out_a_ff ^ req_chan.data_in;
                     out_a_in = req_chan.data_in;
                  end else begin
                     dir_a_in = req_chan.data_in;
                  end
               end
               RS_CTRL_A: begin
                  ctrl_a_in = {ctrl_a_ff[7:6], req_chan.data_in[5:0]};
                  // Line 2 follows the control word, takes the pin level, or holds.
                  if (ctrl_a_in[CR_L2_OUT]) begin
                     if (ctrl_a_in[CR_L2_MAN]) begin
                        events_in[EV_UPD_CA2] = 1'b1;
                        lines_in[LN_CA2] = ctrl_a_in[CR_L2_LVL];
                        if (ctrl_a_in[CR_L2_LVL] != lines_ff[LN_CA2]) begin
                           events_in[EV_CA2_CHG] = 1'b1;
                        end
                     end
                  end else begin
                     lines_in[LN_CA2] = pins2_ff[0];
                     if (pins2_ff[0] != lines_ff[LN_CA2]) begin
                        events_in[EV_CA2_CHG] = 1'b1;
                        events_in[EV_UPD_CA2] = 1'b1;
                     end
                  end
               end
               RS_PORT_B: begin
                  if (ctrl_b_ff[CR_DATA_SEL]) begin
                     events_in[EV_UPD_PB] = 1'b1;
                     tog_b_in = out_b_ff ^ req_chan.data_in;
                     out_b_in = req_chan.data_in;
                     if (ctrl_b_ff[5:3] == L2_STROBE_MODE) begin
                        events_in[EV_CB2_STB] = 1'b1;
                     end
                  end else begin
                     dir_b_in = req_chan.data_in;
                  end
               end
               default: begin
                  ctrl_b_in = {ctrl_b_ff[7:6], req_chan.data_in[5:0]};
                  if (ctrl_b_in[CR_L2_OUT]) begin
                     if (ctrl_b_in[CR_L2_MAN]) begin
                        events_in[EV_UPD_CB2] = 1'b1;
                        lines_in[LN_CB2] = ctrl_b_in[CR_L2_LVL];
                        if (ctrl_b_in[CR_L2_LVL] != lines_ff[LN_CB2]) begin
                           events_in[EV_CB2_CHG] = 1'b1;
                        end
                     end
                  end else begin
                     lines_in[LN_CB2] = pins2_ff[1];
                     if (pins2_ff[1] != lines_ff[LN_CB2]) begin
                        events_in[EV_CB2_CHG] = 1'b1;
                        events_in[EV_UPD_CB2] = 1'b1;
                     end
                  end
               end
            endcase
         end
         OP_SET_CA1: begin
            if (level != lines_ff[LN_CA1]) begin
               lines_in[LN_CA1] = level;
               if (ctrl_a_ff[CR_L1_EDGE] == level) begin
                  ctrl_a_in[CR_IRQ1] = 1'b1;
               end
            end
         end
         OP_SET_CA2: begin
            pins2_in[0] = level;
            if (level != lines_ff[LN_CA2]) begin
               lines_in[LN_CA2] = level;
               if (ctrl_a_ff[CR_L2_MAN] == level) begin
                  ctrl_a_in[CR_IRQ2] = 1'b1;
               end
            end
         end
         OP_SET_CB1: begin
            if (level != lines_ff[LN_CB1]) begin
               lines_in[LN_CB1] = level;
               if (ctrl_b_ff[CR_L1_EDGE] == level) begin
                  ctrl_b_in[CR_IRQ1] = 1'b1;
               end
            end
         end
         OP_SET_CB2: begin
            pins2_in[1] = level;
            if (level != lines_ff[LN_CB2]) begin
               lines_in[LN_CB2] = level;
               if (ctrl_b_ff[CR_L2_MAN] == level) begin
                  ctrl_b_in[CR_IRQ2] = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_a_ff    <= '0;
         ctrl_b_ff    <= '0;
         dir_a_ff     <= '0;
         dir_b_ff     <= '0;
         out_a_ff     <= '0;
         out_b_ff     <= '0;
         tog_a_ff     <= '0;
         tog_b_ff     <= '0;
         events_ff    <= '0;
         lines_ff     <= '0;
         pins2_ff     <= 2'b11;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            ctrl_a_ff <= ctrl_a_in;
            ctrl_b_ff <= ctrl_b_in;
            dir_a_ff  <= dir_a_in;
            dir_b_ff  <= dir_b_in;
            out_a_ff  <= out_a_in;
            out_b_ff  <= out_b_in;
            tog_a_ff  <= tog_a_in;
            tog_b_ff  <= tog_b_in;
            events_ff <= events_in;
            lines_ff  <= lines_in;
            pins2_ff  <= pins2_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload register; loaded only when a request is accepted.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_chan.read_data      <= read_byte;
         rsp_chan.port_a_out     <= out_a_in;
         rsp_chan.port_b_out     <= out_b_in;
         rsp_chan.port_a_toggled <= tog_a_in;
         rsp_chan.port_b_toggled <= tog_b_in;
         rsp_chan.ca2_level      <= lines_in[LN_CA2];
         rsp_chan.cb2_level      <= lines_in[LN_CB2];
         rsp_chan.ca2_flipped    <= events_in[EV_CA2_CHG];
         rsp_chan.cb2_flipped    <= events_in[EV_CB2_CHG];
         rsp_chan.ca2_strobe     <= events_in[EV_CA2_STB];
         rsp_chan.cb2_strobe     <= events_in[EV_CB2_STB];
         rsp_chan.updated_mask   <= events_in[EV_UPD_PB:EV_UPD_CA2];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_chan.valid)
      else $error("accepted request did not produce a response");

   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.opcode != OP_READ |=> rsp_chan.read_data == '0)
      else $error("read_data nonzero for a request that is not a read");

   a_change_implies_update: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (!rsp_chan.ca2_flipped || rsp_chan.updated_mask[0]) &&
                         (!rsp_chan.cb2_flipped || rsp_chan.updated_mask[1]))
      else $error("line 2 change flagged without its update bit");

   a_toggle_implies_update: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.port_a_toggled == '0 || rsp_chan.updated_mask[2]) &&
                         (rsp_chan.port_b_toggled == '0 || rsp_chan.updated_mask[3]))
      else $error("port toggle mask set without its update bit");

endmodule
